### src/ghvf_pkg.sv
// gamepad hotkey volume filter: shared types and constants
// no dependencies
`default_nettype none

package ghvf_pkg;

  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 24;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned CfgW     = 16;
  localparam int unsigned VolW     = 7;

  localparam logic [VolW-1:0] VolMax   = 7'd100;
  localparam logic [VolW-1:0] VolReset = 7'd40;

  localparam logic [CfgW-1:0] LongPressReset = 16'd4000;
  localparam logic [CfgW-1:0] RepeatReset    = 16'd150;
  localparam logic [CfgW-1:0] SaveDelayReset = 16'd1000;
  localparam logic [VolW-1:0] VolStepReset   = 7'd5;

  // button positions in pad order
  localparam int unsigned BtnUp     = 0;
  localparam int unsigned BtnDown   = 1;
  localparam int unsigned BtnSelect = 4;
  localparam int unsigned BtnStart  = 5;
  // remote swaps start and select
  localparam int unsigned RemStart  = 4;
  localparam int unsigned RemSelect = 5;

  typedef enum logic [1:0] {
    RegLongPress  = 2'd0,
    RegRepeat     = 2'd1,
    RegSaveDelay  = 2'd2,
    RegVolumeStep = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [TimeW-1:0] now_ms;
    logic [7:0]       remote_buttons;
    logic [7:0]       pad_buttons_n;
  } in_item_t;

  typedef struct packed {
    logic [5:0]      pad;
    logic            save_request;
    logic            restart_request;
    logic            volume_mode;
    logic [VolW-1:0] volume_level;
    logic [7:0]      mask_n;
  } out_item_t;

endpackage

`default_nettype wire

### src/gamepad_hotkey_volume_filter.sv
// gamepad hotkey volume filter top level: input register, update logic, result register
// depends on ghvf_pkg
// datapath: an accepted item is held in the input register, then moves into the result register
// throughput: 1 item per cycle while the output is not stalled; state updates as an item moves into the result register
// reset: volume 40, config registers at defaults, hold and save tracking cleared
`default_nettype none

module gamepad_hotkey_volume_filter (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid,
  output      logic                           s_axis_tready,
  // pad_buttons_n[7:0], remote_buttons[15:8], now_ms[47:16]
  input  wire logic [ghvf_pkg::InDataW-1:0]   s_axis_tdata,
  output      logic                           m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // mask_n[7:0], volume_level[14:8], volume_mode[15], restart_request[16],
  // save_request[17], zero pad[23:18]
  output      logic [ghvf_pkg::OutDataW-1:0]  m_axis_tdata,
  input  wire logic                           cfg_valid_i,
  output      logic                           cfg_ready_o,
  input  wire logic [1:0]                     cfg_index_i,
  input  wire logic [ghvf_pkg::CfgW-1:0]      cfg_data_i
);
  import ghvf_pkg::*;

  logic            in_valid_q;
  in_item_t        in_q;
  logic            out_valid_q;
  out_item_t       out_q, out_d;
  logic            advance;

  logic [CfgW-1:0] long_press_q, repeat_q, save_delay_q;
  logic [VolW-1:0] step_size_q;

  logic [VolW-1:0]  volume_q, volume_d;
  logic             start_held_q, start_held_d;
  logic [TimeW-1:0] start_since_q, start_since_d;
  logic [TimeW-1:0] last_step_q, last_step_d;
  logic             save_pending_q, save_pending_d;
  logic [TimeW-1:0] change_time_q, change_time_d;

  logic [7:0]       pressed, pressed_vis;
  logic             up, down, sel, start, vmode, restart, save;
  logic [VolW:0]    vol_sum;
  logic [TimeW-1:0] start_age, step_age, change_age;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign cfg_ready_o   = 1'b1;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_press_q <= LongPressReset;
      repeat_q     <= RepeatReset;
      save_delay_q <= SaveDelayReset;
      step_size_q  <= VolStepReset;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        RegLongPress:  long_press_q <= cfg_data_i;
        RegRepeat:     repeat_q     <= cfg_data_i;
        RegSaveDelay:  save_delay_q <= cfg_data_i;
        RegVolumeStep: step_size_q  <= cfg_data_i[VolW-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_q <= in_item_t'(s_axis_tdata);
    end
  end

  // update logic
  always_comb begin
    pressed = ~in_q.pad_buttons_n | (in_q.remote_buttons & 8'hCF);
    pressed[BtnStart]  = pressed[BtnStart]  | in_q.remote_buttons[RemStart];
    pressed[BtnSelect] = pressed[BtnSelect] | in_q.remote_buttons[RemSelect];

    up    = pressed[BtnUp];
    down  = pressed[BtnDown];
    sel   = pressed[BtnSelect];
    start = pressed[BtnStart];

    start_age  = in_q.now_ms - start_since_q;
    step_age   = in_q.now_ms - last_step_q;

    start_held_d  = start_held_q;
    start_since_d = start_since_q;
    restart       = 1'b0;
    if (start) begin
      if (!start_held_q) begin
        start_since_d = in_q.now_ms;
        start_held_d  = 1'b1;
      end else if (start_age >= {16'd0, long_press_q}) begin
        restart = 1'b1;
      end
    end else begin
      start_held_d = 1'b0;
    end

    vol_sum        = {1'b0, volume_q} + {1'b0, step_size_q};
    volume_d       = volume_q;
    last_step_d    = last_step_q;
    save_pending_d = save_pending_q;
    change_time_d  = change_time_q;
    vmode          = sel && (up || down);
    pressed_vis    = pressed;
    if (vmode) begin
      if (step_age >= {16'd0, repeat_q}) begin
        last_step_d = in_q.now_ms;
        if (up && volume_q < VolMax) begin
          volume_d       = (vol_sum > {1'b0, VolMax}) ? VolMax : vol_sum[VolW-1:0];
          save_pending_d = 1'b1;
          change_time_d  = in_q.now_ms;
        end else if (down && volume_q != '0) begin
          volume_d       = (step_size_q >= volume_q) ? '0 : volume_q - step_size_q;
          save_pending_d = 1'b1;
          change_time_d  = in_q.now_ms;
        end
      end
      pressed_vis = pressed & 8'hEC;
    end

    change_age = in_q.now_ms - change_time_d;
    save       = 1'b0;
    if (save_pending_d && change_age >= {16'd0, save_delay_q}) begin
      save           = 1'b1;
      save_pending_d = 1'b0;
    end

    out_d.pad             = '0;
    out_d.save_request    = save;
    out_d.restart_request = restart;
    out_d.volume_mode     = vmode;
    out_d.volume_level    = volume_d;
    out_d.mask_n          = ~pressed_vis;
  end

  // state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q    <= 1'b0;
      volume_q       <= VolReset;
      start_held_q   <= 1'b0;
      start_since_q  <= '0;
      last_step_q    <= '0;
      save_pending_q <= 1'b0;
      change_time_q  <= '0;
    end else begin
      if (advance) begin
        out_valid_q    <= 1'b1;
        volume_q       <= volume_d;
        start_held_q   <= start_held_d;
        start_since_q  <= start_since_d;
        last_step_q    <= last_step_d;
        save_pending_q <= save_pending_d;
        change_time_q  <= change_time_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  // checks
  a_volume_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    volume_q <= VolMax)
    else $error("volume above maximum");

  a_vmode_hides: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.volume_mode) |->
      (out_q.mask_n[BtnUp] && out_q.mask_n[BtnDown] && out_q.mask_n[BtnSelect]))
    else $error("hotkey buttons visible in volume mode");

  a_restart_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.restart_request) |-> !out_q.mask_n[BtnStart])
    else $error("restart without start pressed");

  a_save_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && out_d.save_request) |=> !save_pending_q)
    else $error("save pending after save request");

endmodule

`default_nettype wire

### tb/gamepad_hotkey_volume_filter_test.sv
// testbench for gamepad_hotkey_volume_filter: stream driver, result monitor and poll predictor
// depends on ghvf_pkg and the gamepad_hotkey_volume_filter rtl
`timescale 1ns / 100ps

module gamepad_hotkey_volume_filter_test;
  import ghvf_pkg::*;

  typedef struct {
    bit                is_cfg;
    cfg_reg_e          cfg_sel;
    logic [CfgW-1:0]   value;
    in_item_t          poll;
  } drive_op_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [1:0]          cfg_index_i = '0;
  logic [CfgW-1:0]     cfg_data_i = '0;

  gamepad_hotkey_volume_filter u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  drive_op_t   pending_ops[$];
  out_item_t   merged_polls[$];
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          fails = 0;
  int          polls_checked = 0;
  int          restarts_seen = 0;
  int          saves_seen = 0;
  int          settings_done = 0;
  logic [31:0] clock_ms = '0;

  // filter state and registers
  logic [CfgW-1:0] hold_limit = LongPressReset;
  logic [CfgW-1:0] repeat_gap = RepeatReset;
  logic [CfgW-1:0] save_gap   = SaveDelayReset;
  logic [VolW-1:0] step_size  = VolStepReset;
  logic [VolW-1:0] vol_now    = VolReset;
  logic            start_down = 1'b0;
  logic [31:0]     start_t0   = '0;
  logic [31:0]     step_t     = '0;
  logic            save_armed = 1'b0;
  logic [31:0]     change_t   = '0;

  function automatic out_item_t merge_poll(in_item_t it);
    logic [7:0] pressed;
    logic       up, down, sel, vmode;
    logic [7:0] sum;
    out_item_t  res;
    res = '0;
    pressed = ~it.pad_buttons_n | (it.remote_buttons & 8'hCF);
    pressed[BtnStart]  = pressed[BtnStart] | it.remote_buttons[RemStart];
    pressed[BtnSelect] = pressed[BtnSelect] | it.remote_buttons[RemSelect];
    up   = pressed[BtnUp];
    down = pressed[BtnDown];
    sel  = pressed[BtnSelect];
    if (pressed[BtnStart]) begin
      if (!start_down) begin
        start_t0 = it.now_ms;
        start_down = 1'b1;
      end else if (it.now_ms - start_t0 >= {16'd0, hold_limit}) begin
        res.restart_request = 1'b1;
      end
    end else begin
      start_down = 1'b0;
    end
    vmode = sel && (up || down);
    if (vmode) begin
      if (it.now_ms - step_t >= {16'd0, repeat_gap}) begin
        step_t = it.now_ms;
        if (up && vol_now < VolMax) begin
          sum = {1'b0, vol_now} + {1'b0, step_size};
          vol_now = (sum > {1'b0, VolMax}) ? VolMax : sum[VolW-1:0];
          save_armed = 1'b1;
          change_t = it.now_ms;
        end else if (down && vol_now != '0) begin
          vol_now = (step_size >= vol_now) ? '0 : vol_now - step_size;
          save_armed = 1'b1;
          change_t = it.now_ms;
        end
      end
      pressed[BtnSelect] = 1'b0;
      pressed[BtnUp] = 1'b0;
      pressed[BtnDown] = 1'b0;
    end
    if (save_armed && it.now_ms - change_t >= {16'd0, save_gap}) begin
      res.save_request = 1'b1;
      save_armed = 1'b0;
    end
    res.mask_n = ~pressed;
    res.volume_level = vol_now;
    res.volume_mode = vmode;
    return res;
  endfunction

  // driver: items and register writes from the pending queue
  always @(posedge clk_i) begin : driver
    drive_op_t op;
    if (s_axis_tvalid && s_axis_tready) merged_polls.push_back(merge_poll(s_axis_tdata));
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        RegLongPress:  hold_limit = cfg_data_i;
        RegRepeat:     repeat_gap = cfg_data_i;
        RegSaveDelay:  save_gap = cfg_data_i;
        RegVolumeStep: step_size = cfg_data_i[VolW-1:0];
        default: ;
      endcase
    end
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      cfg_valid_i <= 1'b0;
    end else if (!((s_axis_tvalid && !s_axis_tready) || (cfg_valid_i && !cfg_ready_o))) begin
      if (pending_ops.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        op = pending_ops.pop_front();
        s_axis_tvalid <= !op.is_cfg;
        cfg_valid_i <= op.is_cfg;
        s_axis_tdata <= op.poll;
        cfg_index_i <= op.cfg_sel;
        cfg_data_i <= op.value;
      end else begin
        s_axis_tvalid <= 1'b0;
        cfg_valid_i <= 1'b0;
      end
    end
  end

  task automatic check_field(input string field, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
      fails++;
    end
  endtask

  // monitor: random stalls and result checks
  always @(posedge clk_i) begin : monitor
    out_item_t got, want;
    if (!rst_ni) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    if (m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (merged_polls.size() == 0) begin
        $display("%0t: unexpected item, expected none actual %h", $time, m_axis_tdata);
        fails++;
      end else begin
        want = merged_polls.pop_front();
        check_field("mask_n", 32'(want.mask_n), 32'(got.mask_n));
        check_field("volume_level", 32'(want.volume_level), 32'(got.volume_level));
        check_field("volume_mode", 32'(want.volume_mode), 32'(got.volume_mode));
        check_field("restart_request", 32'(want.restart_request), 32'(got.restart_request));
        check_field("save_request", 32'(want.save_request), 32'(got.save_request));
        check_field("zero pad", 32'(want.pad), 32'(got.pad));
        polls_checked++;
        restarts_seen += int'(got.restart_request);
        saves_seen += int'(got.save_request);
      end
    end
  end

  task automatic push_cfg(input cfg_reg_e sel, input logic [CfgW-1:0] value);
    drive_op_t op;
    op.is_cfg = 1'b1;
    op.cfg_sel = sel;
    op.value = value;
    op.poll = '0;
    pending_ops.push_back(op);
  endtask

  task automatic push_poll(input logic [7:0] pad_n, input logic [7:0] rem, input logic [31:0] t);
    drive_op_t op;
    op.is_cfg = 1'b0;
    op.cfg_sel = RegLongPress;
    op.value = '0;
    op.poll.pad_buttons_n = pad_n;
    op.poll.remote_buttons = rem;
    op.poll.now_ms = t;
    pending_ops.push_back(op);
  endtask

  // runs of held buttons (volume up/down, start) with noise mixed in
  task automatic queue_button_runs(input int count);
    int         left, run, mode;
    logic [7:0] want, split, pad_p, rem_p;
    left = count;
    while (left > 0) begin
      run = $urandom_range(1, 20);
      mode = $urandom_range(0, 9);
      for (int i = 0; i < run && left > 0; i++) begin
        case (mode)
          0, 1:    want = 8'h11;
          2, 3:    want = 8'h12;
          4:       want = 8'h13;
          5, 6:    want = 8'h20;
          7:       want = 8'h00;
          default: want = 8'($urandom);
        endcase
        if ($urandom_range(0, 3) == 0) want = want | (8'($urandom) & 8'hCC);
        split = 8'($urandom);
        pad_p = want & split;
        rem_p = want & ~split;
        if ($urandom_range(0, 1) == 0) rem_p = rem_p | (want & 8'($urandom));
        if ($urandom_range(0, 19) == 0) clock_ms = $urandom;
        else if ($urandom_range(0, 9) == 0) clock_ms = clock_ms + $urandom_range(0, 70000);
        else clock_ms = clock_ms + $urandom_range(0, 400);
        if ($urandom_range(0, 9) == 0) push_poll(8'($urandom), 8'($urandom), clock_ms);
        else push_poll(~pad_p, {rem_p[7:6], rem_p[4], rem_p[5], rem_p[3:0]}, clock_ms);
        left--;
      end
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_ops.size() != 0 || s_axis_tvalid || cfg_valid_i || merged_polls.size() != 0);
  endtask

  initial begin : stimulus
    int lp, rp, sd, st;
    send_idle_pct = 28;
    recv_stall_pct = 85;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: step 60 reaches both volume limits quickly
    push_cfg(RegVolumeStep, 16'd60);
    push_poll(8'hFF, 8'h00, 32'd0);
    push_poll(8'h00, 8'hFF, 32'd0);
    push_poll(8'hEE, 8'h00, 32'd150);
    push_poll(8'hEC, 8'h00, 32'd300);
    push_poll(8'hED, 8'h00, 32'd450);
    push_poll(8'hED, 8'h00, 32'd600);
    push_poll(8'hFF, 8'h00, 32'd1600);
    push_poll(8'hFF, 8'h21, 32'd1750);
    push_poll(8'hFF, 8'h21, 32'd1800);
    push_poll(8'hDF, 8'h00, 32'hFFFF_F000);
    push_poll(8'hDF, 8'h00, 32'h0000_0100);
    push_poll(8'hFF, 8'h10, 32'h0000_0200);
    push_poll(8'hFF, 8'h00, 32'h0000_0300);
    push_poll(8'hFF, 8'h10, 32'hFFFF_FFFF);
    push_poll(8'h00, 8'h00, 32'hFFFF_FFFF);
    push_poll(8'hFF, 8'hFF, 32'h0000_0000);
    push_poll(8'h55, 8'hAA, 32'h1234_5678);
    push_poll(8'hAA, 8'h55, 32'h8765_4321);
    wait_drained();
    settings_done++;

    for (int p = 0; p < 6; p++) begin
      case (p)
        0:       begin lp = 0;     rp = 0;     sd = 0;     st = 1;   end
        1:       begin lp = 65535; rp = 65535; sd = 65535; st = 100; end
        2:       begin lp = 500;   rp = 100;   sd = 300;   st = 0;   end
        3:       begin lp = 1000;  rp = 50;    sd = 200;   st = 127; end
        4: begin
          lp = $urandom_range(0, 65535);
          rp = $urandom_range(0, 400);
          sd = $urandom_range(0, 2000);
          st = $urandom_range(1, 100);
        end
        default: begin lp = 4000;  rp = 150;   sd = 1000;  st = 5;   end
      endcase
      if (p >= 4) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end else if (p >= 2) begin
        send_idle_pct = 85;
        recv_stall_pct = 28;
      end
      push_cfg(RegLongPress, 16'(lp));
      push_cfg(RegRepeat, 16'(rp));
      push_cfg(RegSaveDelay, 16'(sd));
      push_cfg(RegVolumeStep, 16'(st));
      clock_ms = $urandom;
      queue_button_runs(300);
      wait_drained();
      settings_done++;
    end

    repeat (20) @(negedge clk_i);
    $display("checked %0d polls under %0d register settings", polls_checked, settings_done);
    $display("saw %0d restart and %0d save requests", restarts_seen, saves_seen);
    if (fails == 0 && merged_polls.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("timeout with %0d items outstanding", merged_polls.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule

### gamepad_hotkey_volume_filter.f
src/ghvf_pkg.sv
src/gamepad_hotkey_volume_filter.sv
tb/gamepad_hotkey_volume_filter_test.sv
